@@ rtl/core/pcrg_pkg.sv @@
`timescale 1ns / 1ps

package pcrg_pkg;

	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 4;
	localparam int COMP_W    = 16;
	localparam int DIR_FRAC  = 14;
	localparam int NORM_W    = 30;
	localparam int NORM_TOP  = 29;
	localparam int SQ_W      = 62;
	localparam int ROOT_W    = 31;
	localparam int ISQ_STEPS = 31;
	localparam int ND_QW     = 15;
	localparam int ND_DW     = NORM_W + DIR_FRAC + 1;

	localparam logic [47:0] RST_BASIS_U = 48'h0000_0000_4000;
	localparam logic [47:0] RST_BASIS_V = 48'h0000_4000_0000;
	localparam logic [47:0] RST_BASIS_N = 48'h4000_0000_0000;
	localparam logic [15:0] RST_DIST    = 16'd2560;
	localparam logic [15:0] RST_WIDTH   = 16'd1024;
	localparam logic [15:0] RST_HEIGHT  = 16'd768;
	localparam logic [12:0] RST_COLS    = 13'd640;
	localparam logic [12:0] RST_ROWS    = 13'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASIS_U  = 4'd0,
		REG_BASIS_V  = 4'd1,
		REG_BASIS_N  = 4'd2,
		REG_DIST     = 4'd3,
		REG_WIDTH    = 4'd4,
		REG_HEIGHT   = 4'd5,
		REG_COLS     = 4'd6,
		REG_ROWS     = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
	} pcrg_in_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} pcrg_out_t;

endpackage

@@ rtl/core/pinhole_camera_ray_generator_unit.sv @@
`timescale 1ns / 1ps
// throughput: one pixel per cycle while the output is not stalled; every stage is a register of one pipelined datapath
// (two plane-coordinate dividers, basis products, integer square root, three dividers)
// a stalled output holds the whole pipeline in place
// reset: async active low, clears pipeline valids and loads the default camera registers

module pinhole_camera_ray_generator_unit import pcrg_pkg::*; #(
	parameter int RES_BITS  = 12,
	parameter int FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pcrg_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pcrg_out_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int QW   = FRAC_BITS + 8;
	localparam int AW   = QW + 1;
	localparam int DW   = RES_BITS + FRAC_BITS + 9;
	localparam int DENW = RES_BITS + 1;
	localparam int CW   = FRAC_BITS + 26;
	localparam int MW   = CW - 1;
	localparam int NG   = (MW + 7) / 8;
	localparam int PW   = $clog2(NG * 8);
	localparam int NS   = QW + 59;

	logic [47:0] basis_u_q, basis_v_q, basis_n_q;
	logic [15:0] plane_distance_q, plane_width_q, plane_height_q;
	logic [12:0] columns_total_q, rows_total_q;

	logic          adv;
	logic [NS-1:0] vld_s;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_u_q        <= RST_BASIS_U;
			basis_v_q        <= RST_BASIS_V;
			basis_n_q        <= RST_BASIS_N;
			plane_distance_q <= RST_DIST;
			plane_width_q    <= RST_WIDTH;
			plane_height_q   <= RST_HEIGHT;
			columns_total_q  <= RST_COLS;
			rows_total_q     <= RST_ROWS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASIS_U: basis_u_q        <= cfg_data;
				REG_BASIS_V: basis_v_q        <= cfg_data;
				REG_BASIS_N: basis_n_q        <= cfg_data;
				REG_DIST:    plane_distance_q <= cfg_data[15:0];
				REG_WIDTH:   plane_width_q    <= cfg_data[15:0];
				REG_HEIGHT:  plane_height_q   <= cfg_data[15:0];
				REG_COLS:    columns_total_q  <= cfg_data[12:0];
				REG_ROWS:    rows_total_q     <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign adv       = !vld_s[NS-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-2:0], in_valid};
		end
	end

	function automatic logic [RES_BITS-1:0] last_index(input logic [12:0] total);
		int res;
		res = int'(total);
		if (res < 2) res = 2;
		if (res > (1 << RES_BITS)) res = 1 << RES_BITS;
		return RES_BITS'(res - 1);
	endfunction

	// stage 1: clamp and center
	logic [RES_BITS-1:0] a_d_c, b_d_c, a_at_c, b_at_c;
	logic                a_ng_c, b_ng_c;
	logic [RES_BITS-1:0] a_d_s1, b_d_s1, a_at_s1, b_at_s1;
	logic                a_ng_s1, b_ng_s1;

	always_comb begin
		int ia, ib, ta, tb;
		a_d_c = last_index(columns_total_q);
		b_d_c = last_index(rows_total_q);
		ia = int'(in_data.pixel_col);
		ib = int'(in_data.pixel_row);
		if (ia > int'(a_d_c)) ia = int'(a_d_c);
		if (ib > int'(b_d_c)) ib = int'(b_d_c);
		ta = 2 * ia - int'(a_d_c);
		tb = 2 * ib - int'(b_d_c);
		a_ng_c = ta < 0;
		b_ng_c = tb < 0;
		a_at_c = RES_BITS'(ta < 0 ? -ta : ta);
		b_at_c = RES_BITS'(tb < 0 ? -tb : tb);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_d_s1  <= a_d_c;
			b_d_s1  <= b_d_c;
			a_at_s1 <= a_at_c;
			b_at_s1 <= b_at_c;
			a_ng_s1 <= a_ng_c;
			b_ng_s1 <= b_ng_c;
		end
	end

	// stage 2: scaled numerator and divisor
	logic [DW-1:0]   a_rem_sd [QW+1];
	logic [DW-1:0]   b_rem_sd [QW+1];
	logic [DENW-1:0] a_den_sd [QW+1];
	logic [DENW-1:0] b_den_sd [QW+1];
	logic [QW-1:0]   a_quo_sd [QW+1];
	logic [QW-1:0]   b_quo_sd [QW+1];
	logic            a_ng_sd  [QW+1];
	logic            b_ng_sd  [QW+1];
	logic [15+RES_BITS:0] a_mul_c, b_mul_c;

	assign a_mul_c = plane_width_q * a_at_s1;
	assign b_mul_c = plane_height_q * b_at_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_rem_sd[0] <= (DW'(a_mul_c) << (FRAC_BITS - 8)) + DW'(a_d_s1);
			b_rem_sd[0] <= (DW'(b_mul_c) << (FRAC_BITS - 8)) + DW'(b_d_s1);
			a_den_sd[0] <= {a_d_s1, 1'b0};
			b_den_sd[0] <= {b_d_s1, 1'b0};
			a_quo_sd[0] <= '0;
			b_quo_sd[0] <= '0;
			a_ng_sd[0]  <= a_ng_s1;
			b_ng_sd[0]  <= b_ng_s1;
		end
	end

	// plane coordinate dividers, one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_pdiv
		localparam int BI = QW - 1 - k;
		logic [DW-1:0] a_sub, b_sub;
		logic          a_ge, b_ge;
		logic [QW-1:0] a_q, b_q;

		always_comb begin
			a_sub = DW'(a_den_sd[k]) << BI;
			b_sub = DW'(b_den_sd[k]) << BI;
			a_ge  = a_rem_sd[k] >= a_sub;
			b_ge  = b_rem_sd[k] >= b_sub;
			a_q   = a_quo_sd[k];
			b_q   = b_quo_sd[k];
			a_q[BI] = a_ge;
			b_q[BI] = b_ge;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				a_rem_sd[k+1] <= a_ge ? a_rem_sd[k] - a_sub : a_rem_sd[k];
				b_rem_sd[k+1] <= b_ge ? b_rem_sd[k] - b_sub : b_rem_sd[k];
				a_den_sd[k+1] <= a_den_sd[k];
				b_den_sd[k+1] <= b_den_sd[k];
				a_quo_sd[k+1] <= a_q;
				b_quo_sd[k+1] <= b_q;
				a_ng_sd[k+1]  <= a_ng_sd[k];
				b_ng_sd[k+1]  <= b_ng_sd[k];
			end
		end
	end

	// stage 3: signed alpha and beta
	logic signed [AW-1:0] al_s3, be_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			al_s3 <= a_ng_sd[QW] ? AW'(0) - AW'(a_quo_sd[QW]) : AW'(a_quo_sd[QW]);
			be_s3 <= b_ng_sd[QW] ? AW'(0) - AW'(b_quo_sd[QW]) : AW'(b_quo_sd[QW]);
		end
	end

	// stage 4: basis products
	logic signed [AW+15:0] pu_s4 [3];
	logic signed [AW+15:0] pv_s4 [3];
	logic signed [32:0]    pn_s4 [3];

	for (genvar k = 0; k < 3; k++) begin : g_prod
		always_ff @(posedge clk) begin
			if (adv) begin
				pu_s4[k] <= al_s3 * $signed(basis_u_q[16*k +: 16]);
				pv_s4[k] <= be_s3 * $signed(basis_v_q[16*k +: 16]);
				pn_s4[k] <= $signed({1'b0, plane_distance_q}) * $signed(basis_n_q[16*k +: 16]);
			end
		end
	end

	// stage 5: direction components
	logic signed [CW-1:0] c_s5 [3];

	for (genvar k = 0; k < 3; k++) begin : g_sum
		always_ff @(posedge clk) begin
			if (adv) begin
				c_s5[k] <= CW'(pu_s4[k]) + CW'(pv_s4[k]) - (CW'(pn_s4[k]) <<< (FRAC_BITS - 8));
			end
		end
	end

	// stage 6: magnitudes
	logic [2:0][MW-1:0] mg_s6, mg_s7, mg_s8;
	logic [2:0]         ng_s6, ng_s7, ng_s8, ng_s9, ng_s10;

	for (genvar k = 0; k < 3; k++) begin : g_abs
		always_ff @(posedge clk) begin
			if (adv) begin
				mg_s6[k] <= MW'(c_s5[k] < 0 ? -c_s5[k] : c_s5[k]);
				ng_s6[k] <= c_s5[k] < 0;
			end
		end
	end

	// stage 7: leading one per byte group
	logic [NG*8-1:0]       orv_c;
	logic [NG-1:0]         gnz_c, gnz_s7;
	logic [NG-1:0][2:0]    gpos_c, gpos_s7;

	always_comb begin
		orv_c = (NG*8)'(mg_s6[0] | mg_s6[1] | mg_s6[2]);
		for (int g = 0; g < NG; g++) begin
			gnz_c[g]  = |orv_c[g*8 +: 8];
			gpos_c[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (orv_c[g*8 + b]) gpos_c[g] = 3'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gnz_s7  <= gnz_c;
			gpos_s7 <= gpos_c;
			mg_s7   <= mg_s6;
			ng_s7   <= ng_s6;
		end
	end

	// stage 8: common normalize shift
	logic [PW-1:0] pos_c, sh_c, sh_s8;
	logic          shr_c, shr_s8;
	logic          zr_s8, zr_s9, zr_s10;

	always_comb begin
		pos_c = '0;
		for (int g = 0; g < NG; g++) begin
			if (gnz_s7[g]) pos_c = PW'(g * 8) + PW'(gpos_s7[g]);
		end
		shr_c = pos_c > PW'(NORM_TOP);
		sh_c  = shr_c ? pos_c - PW'(NORM_TOP) : PW'(NORM_TOP) - pos_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sh_s8  <= sh_c;
			shr_s8 <= shr_c;
			zr_s8  <= !(|gnz_s7);
			mg_s8  <= mg_s7;
			ng_s8  <= ng_s7;
		end
	end

	// stage 9: normalized magnitudes
	logic [2:0][NORM_W-1:0] nm_s9, nm_s10;

	for (genvar k = 0; k < 3; k++) begin : g_norm
		always_ff @(posedge clk) begin
			if (adv) begin
				nm_s9[k] <= shr_s8 ? NORM_W'(mg_s8[k] >> sh_s8) : NORM_W'(mg_s8[k] << sh_s8);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ng_s9 <= ng_s8;
			zr_s9 <= zr_s8;
		end
	end

	// stage 10: squares
	logic [2*NORM_W-1:0] sq_s10 [3];

	for (genvar k = 0; k < 3; k++) begin : g_sq
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s10[k] <= nm_s9[k] * nm_s9[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_s10 <= nm_s9;
			ng_s10 <= ng_s9;
			zr_s10 <= zr_s9;
		end
	end

	// stage 11: sum of squares, start of root
	logic [SQ_W-1:0]        rx_si [ISQ_STEPS+1];
	logic [SQ_W-1:0]        rr_si [ISQ_STEPS+1];
	logic [2:0][NORM_W-1:0] nm_si [ISQ_STEPS+1];
	logic [2:0]             ng_si [ISQ_STEPS+1];
	logic                   zr_si [ISQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_si[0] <= SQ_W'(sq_s10[0]) + SQ_W'(sq_s10[1]) + SQ_W'(sq_s10[2]);
			rr_si[0] <= '0;
			nm_si[0] <= nm_s10;
			ng_si[0] <= ng_s10;
			zr_si[0] <= zr_s10;
		end
	end

	// integer square root, one result bit per stage
	for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isqrt
		localparam int BP = 2 * (ISQ_STEPS - 1 - j);
		logic [SQ_W-1:0] bitv, trial;
		logic            ge;

		always_comb begin
			bitv  = SQ_W'(1) << BP;
			trial = rr_si[j] + bitv;
			ge    = rx_si[j] >= trial;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rx_si[j+1] <= ge ? rx_si[j] - trial : rx_si[j];
				rr_si[j+1] <= ge ? (rr_si[j] >> 1) + bitv : rr_si[j] >> 1;
				nm_si[j+1] <= nm_si[j];
				ng_si[j+1] <= ng_si[j];
				zr_si[j+1] <= zr_si[j];
			end
		end
	end

	// normalize dividers
	logic [ROOT_W-1:0]     len_c;
	logic [ND_DW-1:0]      nrem_sn [ND_QW+1][3];
	logic [2:0][ND_QW-1:0] nquo_sn [ND_QW+1];
	logic [ROOT_W-1:0]     nlen_sn [ND_QW+1];
	logic [2:0]            nng_sn  [ND_QW+1];
	logic                  nzr_sn  [ND_QW+1];

	assign len_c = ROOT_W'(rr_si[ISQ_STEPS]);

	for (genvar k = 0; k < 3; k++) begin : g_nd0
		always_ff @(posedge clk) begin
			if (adv) begin
				nrem_sn[0][k] <= (ND_DW'(nm_si[ISQ_STEPS][k]) << DIR_FRAC) + ND_DW'(len_c >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nquo_sn[0] <= '0;
			nlen_sn[0] <= len_c;
			nng_sn[0]  <= ng_si[ISQ_STEPS];
			nzr_sn[0]  <= zr_si[ISQ_STEPS];
		end
	end

	for (genvar s = 0; s < ND_QW; s++) begin : g_ndiv
		localparam int BI = ND_QW - 1 - s;
		logic [ND_DW-1:0]      sub;
		logic [2:0]            ge;
		logic [2:0][ND_QW-1:0] q;

		always_comb begin
			sub = ND_DW'(nlen_sn[s]) << BI;
			q   = nquo_sn[s];
			for (int k = 0; k < 3; k++) begin
				ge[k]    = nrem_sn[s][k] >= sub;
				q[k][BI] = ge[k];
			end
		end

		for (genvar k = 0; k < 3; k++) begin : g_lane
			always_ff @(posedge clk) begin
				if (adv) begin
					nrem_sn[s+1][k] <= ge[k] ? nrem_sn[s][k] - sub : nrem_sn[s][k];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nquo_sn[s+1] <= q;
				nlen_sn[s+1] <= nlen_sn[s];
				nng_sn[s+1]  <= nng_sn[s];
				nzr_sn[s+1]  <= nzr_sn[s];
			end
		end
	end

	// output register
	logic [2:0][COMP_W-1:0] dir_c;
	pcrg_out_t              out_s;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (nzr_sn[ND_QW]) begin
				dir_c[k] = '0;
			end else if (nng_sn[ND_QW][k]) begin
				dir_c[k] = COMP_W'(0) - COMP_W'(nquo_sn[ND_QW][k]);
			end else begin
				dir_c[k] = COMP_W'(nquo_sn[ND_QW][k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s.dir_x <= dir_c[0];
			out_s.dir_y <= dir_c[1];
			out_s.dir_z <= dir_c[2];
		end
	end

	assign out_data = out_s;

endmodule
